// ----- hdl/blt_pkg.sv -----
// blt_pkg: shared types, constants and the level-to-percent mapping for the
// battery level tracker; used by every module in hdl/, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package blt_pkg;

  localparam int unsigned LevelW   = 5;
  localparam int unsigned PercentW = 7;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [LevelW-1:0]   LevelInvalid = 5'h1F;
  localparam logic [PercentW-1:0] PercentFull  = 7'd100;
  localparam logic [PercentW-1:0] PercentZero  = 7'd0;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegTableSelect  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegEmptyLevel   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNinetyLevel  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFullLevel    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSavedLevel   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDebounceLim  = 3'd5;

  typedef struct packed {
    logic [LevelW-1:0] measured_level;
    logic              charger_present;
    logic              charge_done;
    logic              startup_elapsed;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0]   level;
    logic [PercentW-1:0] percent;
    logic                save_request;
    logic                update_flag;
    logic                tracking_ready;
  } out_item_t;

  typedef struct packed {
    logic              table_select;
    logic [LevelW-1:0] empty_level;
    logic [LevelW-1:0] ninety_level;
    logic [LevelW-1:0] full_level;
    logic [LevelW-1:0] saved_level;
    logic [CountW-1:0] debounce_limit;
  } cfg_t;

  typedef logic [PercentW-1:0] pct_tbl8_t  [8];
  typedef logic [PercentW-1:0] pct_tbl16_t [16];

  localparam pct_tbl8_t PctTbl8 = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd40, 7'd60, 7'd80, 7'd100
  };

  localparam pct_tbl16_t PctTbl16 = '{
    7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd30, 7'd40, 7'd50,
    7'd60, 7'd70, 7'd80, 7'd90, 7'd100, 7'd100, 7'd100, 7'd100
  };

  // clamp at the empty and full levels, otherwise look up the offset
  function automatic logic [PercentW-1:0] level_to_percent(
    input logic [LevelW-1:0] lvl,
    input cfg_t              cfg
  );
    logic [LevelW-1:0]   diff;
    logic [PercentW-1:0] pct;
    diff = lvl - cfg.empty_level;
    if (lvl <= cfg.empty_level) begin
      pct = PercentZero;
    end else if (lvl >= cfg.full_level) begin
      pct = PercentFull;
    end else if (cfg.table_select) begin
      pct = PctTbl16[diff[3:0]];
    end else begin
      pct = PctTbl8[diff[2:0]];
    end
    return pct;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/battery_level_tracker_top.sv -----
// battery_level_tracker_top: input register, tick update and result register
// depends on blt_pkg, blt_cfg_regs and blt_step
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------
//  in       | in        | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//  out      | out       | out_valid_o/out_stall_i | out_data_o (out_item_t)
//  cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one tick per request: a request waits in the input register, the update
// logic runs while it moves into the result register, and one request is
// taken every cycle unless a stall on the output holds the result register.
// reset clears the tracker state and loads the register defaults.
// a stall on the output holds the result register; the input register then
// fills and in_stall_o rises. cfg writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module battery_level_tracker_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire blt_pkg::in_item_t            in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output blt_pkg::out_item_t                out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [blt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [blt_pkg::CfgDataW-1:0] cfg_data_i
);

  blt_pkg::cfg_t      cfg;
  blt_pkg::in_item_t  in_q;
  blt_pkg::out_item_t result;
  blt_pkg::out_item_t out_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               out_free;
  logic               step;
  logic               in_take;

  assign cfg_ready_o = 1'b1;

  blt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake between the two register stages
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  blt_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/blt_cfg_regs.sv -----
// blt_cfg_regs: configuration register file of the battery level tracker
// depends on blt_pkg for register indexes and the cfg_t struct
`timescale 1ns / 1ps
`default_nettype none

module blt_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [blt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [blt_pkg::CfgDataW-1:0]  cfg_data_i,
  output blt_pkg::cfg_t                      cfg_o
);

  blt_pkg::cfg_t cfg_q, cfg_d;

  // decode the register index of a write request
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        blt_pkg::RegTableSelect: cfg_d.table_select   = cfg_data_i[0];
        blt_pkg::RegEmptyLevel:  cfg_d.empty_level    = cfg_data_i[blt_pkg::LevelW-1:0];
        blt_pkg::RegNinetyLevel: cfg_d.ninety_level   = cfg_data_i[blt_pkg::LevelW-1:0];
        blt_pkg::RegFullLevel:   cfg_d.full_level     = cfg_data_i[blt_pkg::LevelW-1:0];
        blt_pkg::RegSavedLevel:  cfg_d.saved_level    = cfg_data_i[blt_pkg::LevelW-1:0];
        blt_pkg::RegDebounceLim: cfg_d.debounce_limit = cfg_data_i[blt_pkg::CountW-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.table_select   <= 1'b0;
      cfg_q.empty_level    <= '0;
      cfg_q.ninety_level   <= '0;
      cfg_q.full_level     <= blt_pkg::LevelInvalid;
      cfg_q.saved_level    <= blt_pkg::LevelInvalid;
      cfg_q.debounce_limit <= 16'd320;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/blt_step.sv -----
// blt_step: tracker state registers and the single-pass update logic for one
// check tick; depends on blt_pkg for item types and the percent mapping
`timescale 1ns / 1ps
`default_nettype none

module blt_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire blt_pkg::in_item_t item_i,
  input  wire blt_pkg::cfg_t     cfg_i,
  output blt_pkg::out_item_t     result_o
);

  logic                              first_pass_q, first_pass_d;
  logic [blt_pkg::LevelW-1:0]        level_q, level_d;
  logic [blt_pkg::CountW-1:0]        count_q, count_d;
  logic [blt_pkg::PercentW-1:0]      percent_q, percent_d;

  logic [blt_pkg::CountW-1:0]        count_inc;
  logic [blt_pkg::LevelW-1:0]        map_level;
  logic                              save;

  assign count_inc   = count_q + 1'b1;

  // next state for one tick
  always_comb begin
    first_pass_d = first_pass_q;
    level_d      = level_q;
    count_d      = count_q;
    percent_d    = percent_q;
    map_level    = level_q;
    save         = 1'b0;
    if (first_pass_q) begin
      // adopt the saved level, or the measured one once startup is over
      if (cfg_i.saved_level != blt_pkg::LevelInvalid) begin
        map_level    = cfg_i.saved_level;
        first_pass_d = 1'b0;
        level_d      = map_level;
        percent_d    = blt_pkg::level_to_percent(map_level, cfg_i);
      end else if (item_i.startup_elapsed) begin
        map_level    = item_i.measured_level;
        first_pass_d = 1'b0;
        level_d      = map_level;
        percent_d    = blt_pkg::level_to_percent(map_level, cfg_i);
        save         = 1'b1;
      end
    end else if (item_i.charger_present) begin
      if (item_i.measured_level > level_q) begin
        count_d = count_inc;
        if (item_i.charge_done) begin
          level_d = cfg_i.full_level;
          if (percent_q != blt_pkg::PercentFull) begin
            percent_d = blt_pkg::PercentFull;
            save      = 1'b1;
          end
        end else if (count_inc > cfg_i.debounce_limit) begin
          count_d = '0;
          if (cfg_i.ninety_level > level_q) begin
            map_level = level_q + 1'b1;
            level_d   = map_level;
            percent_d = blt_pkg::level_to_percent(map_level, cfg_i);
            save      = 1'b1;
          end
        end
      end
    end else begin
      if (item_i.measured_level < level_q) begin
        count_d = count_inc;
        if (count_inc > cfg_i.debounce_limit) begin
          count_d = '0;
          if (cfg_i.empty_level < level_q) begin
            map_level = level_q - 1'b1;
            level_d   = map_level;
            percent_d = blt_pkg::level_to_percent(map_level, cfg_i);
            save      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pass_q <= 1'b1;
      level_q      <= '0;
      count_q      <= '0;
      percent_q    <= '0;
    end else if (step_i) begin
      first_pass_q <= first_pass_d;
      level_q      <= level_d;
      count_q      <= count_d;
      percent_q    <= percent_d;
    end
  end

  // result of this tick
  always_comb begin
    result_o.level          = level_d;
    result_o.percent        = percent_d;
    result_o.save_request   = save;
    result_o.update_flag    = save;
    result_o.tracking_ready = ~first_pass_d;
  end

endmodule

`default_nettype wire

// ----- hdl/blt_checker.sv -----
// blt_checker: port-level assertions for the battery level tracker, bound
// to battery_level_tracker_top; depends on blt_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module blt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire blt_pkg::out_item_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // save and update are raised together and the percentage stays in range
  a_flags_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.save_request == out_data_o.update_flag) &&
                    (out_data_o.percent <= blt_pkg::PercentFull))
    else $error("inconsistent flags or percentage");

  // before tracking starts the result carries the reset values only
  a_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tracking_ready |->
      !out_data_o.save_request && (out_data_o.level == '0) &&
      (out_data_o.percent == blt_pkg::PercentZero))
    else $error("result changed before tracking started");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind battery_level_tracker_top blt_checker u_blt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
